/* rtl/core/mctc_pkg.sv */
// ----------------------------------------------------------------------------
// mctc_pkg - shared types and constants
// Trie geometry, command and result records, back-end state codes.
// ----------------------------------------------------------------------------
package mctc_pkg;

    localparam int NODE_COUNT  = 64;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int ADDR_BITS   = NODE_BITS + 8;
    localparam int ENTRY_COUNT = NODE_COUNT * 256;
    localparam int FREE_BITS   = $clog2(NODE_COUNT + 1);

    localparam logic [0:0] ACT_INSERT = 1'b0;
    localparam logic [0:0] ACT_LOOKUP = 1'b1;

    localparam logic [1:0] MODE_TABLE    = 2'd0;
    localparam logic [1:0] MODE_FALLBACK = 2'd1;
    localparam logic [1:0] MODE_IDENTITY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COLLIDED  = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic        link;
        logic [15:0] value;
    } entry_t;

    typedef struct packed {
        logic            lookup;
        logic [2:0]      nb;
        logic [31:0]     code_s;
        logic [31:0]     code_e;
        logic [15:0]     cid0;
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } cmd_t;

    typedef struct packed {
        logic [15:0] cid;
        logic [31:0] char_code;
        logic [2:0]  bytes_used;
        logic [1:0]  status;
    } res_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_BLK_START,
        B_WALK_RD,
        B_WALK_CHK,
        B_LEAF_SET,
        B_LEAF_RD,
        B_LEAF_CHK,
        B_NEXT_BLK,
        B_INS_END,
        B_LK_RD,
        B_LK_CHK,
        B_LK_FALL,
        B_DONE
    } back_state_t;

endpackage

/* rtl/core/mctc_req_if.sv */
// ----------------------------------------------------------------------------
// mctc_req_if - request channel
// Valid/ready channel carrying one insert or lookup request.
// ----------------------------------------------------------------------------
interface mctc_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] code_start;
    logic [31:0] code_end;
    logic [2:0]  code_bytes;
    logic [15:0] first_cid;
    logic [7:0]  lookup_byte_0;
    logic [7:0]  lookup_byte_1;
    logic [7:0]  lookup_byte_2;
    logic [7:0]  lookup_byte_3;
    logic [2:0]  lookup_length;

    modport source (
        output valid, action, code_start, code_end, code_bytes, first_cid,
               lookup_byte_0, lookup_byte_1, lookup_byte_2, lookup_byte_3, lookup_length,
        input  ready
    );
    modport sink (
        input  valid, action, code_start, code_end, code_bytes, first_cid,
               lookup_byte_0, lookup_byte_1, lookup_byte_2, lookup_byte_3, lookup_length,
        output ready
    );
endinterface

/* rtl/core/mctc_rsp_if.sv */
// ----------------------------------------------------------------------------
// mctc_rsp_if - result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface mctc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] cid;
    logic [31:0] char_code;
    logic [2:0]  bytes_used;
    logic [1:0]  status;

    modport source (output valid, cid, char_code, bytes_used, status, input ready);
    modport sink   (input valid, cid, char_code, bytes_used, status, output ready);
endinterface

/* rtl/core/mctc_cfg_if.sv */
// ----------------------------------------------------------------------------
// mctc_cfg_if - configuration write channel
// Valid/ready write of the mapping mode register.
// ----------------------------------------------------------------------------
interface mctc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] mapping_mode;

    modport source (output valid, mapping_mode, input ready);
    modport sink   (input valid, mapping_mode, output ready);
endinterface

/* rtl/core/multibyte_code_to_cid_trie_top.sv */
// ----------------------------------------------------------------------------
// multibyte_code_to_cid_trie_top - code to CID trie
// Radix trie of up to four byte levels mapping multibyte codes to CIDs.
// ----------------------------------------------------------------------------
// Use:
//   req  - one request per item: action 0 inserts a code range, 1 looks up
//          up to four code bytes. Every request gives exactly one result.
//   rsp  - cid, char_code, bytes_used, status, held until rsp.ready.
//   cfg  - writes mapping_mode; always ready. Write only while idle.
// Operation:
//   Each trie level read in a lookup is a registered read of the
//   single-port entry memory followed by a check. An insert walks the
//   trie levels of each 256-code block, then reads and checks each code
//   in the block and writes it if free; items are worked one at a time by
//   the trie engine.
//   A two-entry command queue sits between intake and the engine, so up to
//   two requests are taken while the engine is busy or the result waits.
// Reset:
//   After rst_n the engine sweeps all 16384 entries to leaf/CID 0, one per
//   cycle; req.ready stays low until the sweep ends. Node pool restarts
//   with only the root in use and mapping_mode returns to 0.
// Stall:
//   A result not taken holds the result register; the engine then waits
//   with its next result and the queue fills, dropping req.ready.
// ----------------------------------------------------------------------------
module multibyte_code_to_cid_trie_top
    import mctc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mctc_req_if.sink   req,
    mctc_rsp_if.source rsp,
    mctc_cfg_if.sink   cfg
);

    logic [1:0] mode_reg;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic       eng_ready;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    // mode register; taken any cycle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_TABLE;
        else if (cfg.valid)
            mode_reg <= cfg.mapping_mode;
    end

    // intake: clamp and trim, then queue
    mctc_front u_front (
        .en   (eng_ready),
        .req  (req),
        .push (push),
        .cmd  (push_cmd),
        .full (full)
    );

    mctc_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .full  (full),
        .pop   (pop),
        .rdata (head_cmd),
        .empty (empty)
    );

    // trie engine with entry memory and result register
    mctc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .empty         (empty),
        .cmd           (head_cmd),
        .pop           (pop),
        .ready_for_req (eng_ready),
        .rsp           (rsp)
    );

endmodule

/* rtl/core/mctc_front.sv */
// ----------------------------------------------------------------------------
// mctc_front - request intake
// Accepts requests, clamps lengths and trims codes into a command record.
// ----------------------------------------------------------------------------
module mctc_front
    import mctc_pkg::*;
(
    input  logic          en,
    mctc_req_if.sink      req,
    output logic          push,
    output cmd_t          cmd,
    input  logic          full
);

    logic [2:0]  nb;
    logic [31:0] cmask;

    assign req.ready = en && !full;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        if (req.code_bytes == 3'd0)
            nb = 3'd1;
        else if (req.code_bytes > 3'd4)
            nb = 3'd4;
        else
            nb = req.code_bytes;
        case (nb)
            3'd1:    cmask = 32'h0000_00ff;
            3'd2:    cmask = 32'h0000_ffff;
            3'd3:    cmask = 32'h00ff_ffff;
            default: cmask = 32'hffff_ffff;
        endcase
        cmd.lookup = req.action;
        cmd.nb     = nb;
        cmd.code_s = req.code_start & cmask;
        cmd.code_e = req.code_end & cmask;
        cmd.cid0   = req.first_cid;
        cmd.bytes  = {req.lookup_byte_3, req.lookup_byte_2,
                      req.lookup_byte_1, req.lookup_byte_0};
        cmd.len    = (req.lookup_length > 3'd4) ? 3'd4 : req.lookup_length;
    end

endmodule

/* rtl/core/mctc_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mctc_cmd_fifo - command queue
// Two-entry queue decoupling intake from trie execution.
// ----------------------------------------------------------------------------
module mctc_cmd_fifo
    import mctc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/core/mctc_back.sv */
// ----------------------------------------------------------------------------
// mctc_back - trie engine
// Holds the node pool, runs inserts and lookups, drives the result register.
// ----------------------------------------------------------------------------
module mctc_back
    import mctc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] mode,
    input  logic       empty,
    input  cmd_t       cmd,
    output logic       pop,
    output logic       ready_for_req,
    mctc_rsp_if.source rsp
);

    entry_t               mem [ENTRY_COUNT];
    entry_t               rd_reg;
    logic [ADDR_BITS-1:0] addr;
    logic                 we;
    entry_t               wdata;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [23:0]          blk_reg, blk_next;
    logic [7:0]           b_reg, b_next;
    logic [7:0]           hi_reg, hi_next;
    logic                 coll_reg, coll_next;
    logic                 exh_reg, exh_next;
    logic [FREE_BITS-1:0] free_reg, free_next;
    logic [2:0]           n_reg, n_next;
    logic [31:0]          code_reg, code_next;
    res_t                 res_reg, res_next;
    logic                 ovalid_reg, ovalid_next;
    res_t                 odata_reg, odata_next;

    logic [7:0]           lvl_byte;
    logic [7:0]           lk_byte;
    logic [7:0]           lo;
    logic [15:0]          leaf_cid;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    always_comb
    begin
        case (lvl_reg)
            2'd1:    lvl_byte = blk_reg[7:0];
            2'd2:    lvl_byte = blk_reg[15:8];
            default: lvl_byte = blk_reg[23:16];
        endcase
        lk_byte  = cmd_reg.bytes[n_reg[1:0]];
        lo       = (blk_reg == cmd_reg.code_s[31:8]) ? cmd_reg.code_s[7:0] : 8'h00;
        leaf_cid = cmd_reg.cid0 + ({blk_reg[7:0], b_reg} - cmd_reg.code_s[15:0]);
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        clr_next    = clr_reg;
        node_next   = node_reg;
        lvl_next    = lvl_reg;
        blk_next    = blk_reg;
        b_next      = b_reg;
        hi_next     = hi_reg;
        coll_next   = coll_reg;
        exh_next    = exh_reg;
        free_next   = free_reg;
        n_next      = n_reg;
        code_next   = code_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        pop         = 1'b0;
        we          = 1'b0;
        wdata       = '0;
        addr        = {node_reg, b_reg};

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            B_CLEAR:
            begin
                addr     = clr_reg;
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_BITS'(ENTRY_COUNT - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = cmd;
                    node_next = '0;
                    n_next    = 3'd0;
                    code_next = 32'd0;
                    coll_next = 1'b0;
                    exh_next  = 1'b0;
                    blk_next  = cmd.code_s[31:8];
                    if (cmd.lookup == ACT_LOOKUP)
                    begin
                        if (mode != MODE_IDENTITY && cmd.len != 3'd0)
                            state_next = B_LK_RD;
                        else
                            state_next = B_LK_FALL;
                    end
                    else if (cmd.code_s[31:8] > cmd.code_e[31:8])
                        state_next = B_INS_END;
                    else
                        state_next = B_BLK_START;
                end
            end
            B_BLK_START:
            begin
                node_next = '0;
                if (cmd_reg.nb == 3'd1)
                    state_next = B_LEAF_SET;
                else
                begin
                    lvl_next   = 2'(cmd_reg.nb - 3'd1);
                    state_next = B_WALK_RD;
                end
            end
            B_WALK_RD:
            begin
                addr       = {node_reg, lvl_byte};
                state_next = B_WALK_CHK;
            end
            B_WALK_CHK:
            begin
                addr = {node_reg, lvl_byte};
                if (rd_reg.link)
                    node_next = rd_reg.value[NODE_BITS-1:0];
                else if (free_reg >= FREE_BITS'(NODE_COUNT))
                    exh_next = 1'b1;
                else
                begin
                    we        = 1'b1;
                    wdata     = '{link: 1'b1, value: 16'(free_reg)};
                    node_next = free_reg[NODE_BITS-1:0];
                    free_next = free_reg + 1'b1;
                end
                if (!rd_reg.link && free_reg >= FREE_BITS'(NODE_COUNT))
                    state_next = B_NEXT_BLK;
                else if (lvl_reg == 2'd1)
                    state_next = B_LEAF_SET;
                else
                begin
                    lvl_next   = lvl_reg - 2'd1;
                    state_next = B_WALK_RD;
                end
            end
            B_LEAF_SET:
            begin
                b_next  = lo;
                hi_next = (blk_reg == cmd_reg.code_e[31:8]) ? cmd_reg.code_e[7:0] : 8'hff;
                if (lo > ((blk_reg == cmd_reg.code_e[31:8]) ? cmd_reg.code_e[7:0] : 8'hff))
                    state_next = B_NEXT_BLK;
                else
                    state_next = B_LEAF_RD;
            end
            B_LEAF_RD:
            begin
                state_next = B_LEAF_CHK;
            end
            B_LEAF_CHK:
            begin
                if (rd_reg.link)
                    coll_next = 1'b1;
                else
                begin
                    we    = 1'b1;
                    wdata = '{link: 1'b0, value: leaf_cid};
                end
                if (b_reg == hi_reg)
                    state_next = B_NEXT_BLK;
                else
                begin
                    b_next     = b_reg + 8'd1;
                    state_next = B_LEAF_RD;
                end
            end
            B_NEXT_BLK:
            begin
                if (blk_reg == cmd_reg.code_e[31:8])
                    state_next = B_INS_END;
                else
                begin
                    blk_next   = blk_reg + 24'd1;
                    state_next = B_BLK_START;
                end
            end
            B_INS_END:
            begin
                res_next.cid        = 16'd0;
                res_next.char_code  = 32'd0;
                res_next.bytes_used = 3'd1;
                res_next.status     = exh_reg ? ST_EXHAUSTED : (coll_reg ? ST_COLLIDED : ST_OK);
                state_next          = B_DONE;
            end
            B_LK_RD:
            begin
                addr       = {node_reg, lk_byte};
                state_next = B_LK_CHK;
            end
            B_LK_CHK:
            begin
                addr      = {node_reg, lk_byte};
                code_next = {code_reg[23:0], lk_byte};
                n_next    = n_reg + 3'd1;
                node_next = rd_reg.value[NODE_BITS-1:0];
                if (!rd_reg.link)
                begin
                    res_next.cid        = rd_reg.value;
                    res_next.char_code  = {code_reg[23:0], lk_byte};
                    res_next.bytes_used = n_reg + 3'd1;
                    res_next.status     = ST_OK;
                    state_next          = B_DONE;
                end
                else if (n_reg + 3'd1 == cmd_reg.len)
                    state_next = B_LK_FALL;
                else
                    state_next = B_LK_RD;
            end
            B_LK_FALL:
            begin
                res_next.status = ST_OK;
                if ((mode == MODE_FALLBACK || mode == MODE_IDENTITY) && cmd_reg.len >= 3'd2)
                begin
                    res_next.cid        = {cmd_reg.bytes[0], cmd_reg.bytes[1]};
                    res_next.char_code  = {16'd0, cmd_reg.bytes[0], cmd_reg.bytes[1]};
                    res_next.bytes_used = 3'd2;
                end
                else
                begin
                    res_next.cid        = 16'd0;
                    res_next.char_code  = {24'd0, cmd_reg.bytes[0]};
                    res_next.bytes_used = 3'd1;
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            clr_reg    <= '0;
            free_reg   <= FREE_BITS'(1);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            free_reg   <= free_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        node_reg  <= node_next;
        lvl_reg   <= lvl_next;
        blk_reg   <= blk_next;
        b_reg     <= b_next;
        hi_reg    <= hi_next;
        coll_reg  <= coll_next;
        exh_reg   <= exh_next;
        n_reg     <= n_next;
        code_reg  <= code_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
    end

    assign ready_for_req  = (state_reg != B_CLEAR);
    assign rsp.valid      = ovalid_reg;
    assign rsp.cid        = odata_reg.cid;
    assign rsp.char_code  = odata_reg.char_code;
    assign rsp.bytes_used = odata_reg.bytes_used;
    assign rsp.status     = odata_reg.status;

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg >= FREE_BITS'(1) && free_reg <= FREE_BITS'(NODE_COUNT))
        else $error("free node index out of range");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == B_CLEAR || state_reg == B_WALK_CHK || state_reg == B_LEAF_CHK))
        else $error("entry write outside clear or insert");

    a_lk_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_LK_CHK |-> n_reg < cmd_reg.len)
        else $error("lookup walked past its length");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == B_IDLE)
        else $error("command taken while busy");

endmodule
